// ===== sv/scsa_pkg.sv =====
// Package for the size-class slab allocator: geometry constants, codes, helpers.
// No dependencies; used by the allocator top and its testbench.
package scsa_pkg;

    localparam int PageCount    = 64;
    localparam int PageBytes    = 4096;
    localparam int ClassCount   = 7;
    localparam int SmallBytes   = 32;
    localparam int PageW        = $clog2(PageCount);
    localparam int OffW         = $clog2(PageBytes);
    localparam int AddrW        = 18;
    localparam int IdxW         = AddrW - $clog2(SmallBytes);
    localparam int LinkDepth    = 1 << IdxW;
    localparam int ClassW       = 3;
    localparam int CountW       = 19;
    localparam int SlotW        = OffW - $clog2(SmallBytes);
    localparam logic [CountW-1:0] CountMax = '1;

    localparam logic [1:0] KindAlloc   = 2'd0;
    localparam logic [1:0] KindFree    = 2'd1;
    localparam logic [1:0] KindRealloc = 2'd2;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatNoClass = 2'd1;
    localparam logic [1:0] StatNoPage  = 2'd2;
    localparam logic [1:0] StatBadAddr = 2'd3;

    // Block size of a class in bytes.
    function automatic logic [12:0] class_bytes(input logic [ClassW-1:0] c);
        class_bytes = 13'(SmallBytes) << c;
    endfunction

    // Block size of a class in link-index units.
    function automatic logic [SlotW:0] class_units(input logic [ClassW-1:0] c);
        class_units = (SlotW+1)'(1) << c;
    endfunction

    function automatic logic class_usable(input logic [ClassW-1:0] c);
        class_usable = (c < ClassW'(ClassCount)) &&
                       ({1'b0, class_bytes(c)} <= 14'(PageBytes / 2));
    endfunction

endpackage

// ===== sv/scsa_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module scsa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/size_class_slab_allocator_top.sv =====
// Size-class slab allocator: command port with start/busy, strobed result.
// Depends on scsa_pkg and scsa_ram.
//
// Usage: drive kind, request_size, address_present and block_in and pulse
// start while busy is low; the beat is taken at that edge and busy rises.
// One result beat follows, marked by done for a single cycle, carrying
// status, block_out, copy_bytes and used_bytes_now. The receiver cannot
// stall, so the result is simply presented once. Busy stays high through
// the done cycle, so the next beat can be taken in the cycle after it.
// Path from the accepting edge: a bad address goes from decode or the
// check to done, an in-place reallocate through the check, a free through
// the check and the free state, and a pop from a non-empty class through
// alloc, pop-read and pop; decode and pop-read cover the registered reads
// of the page owner memory and the link memory. A fresh page claim writes
// one link per block of the page but the first, one a cycle. A moving
// reallocate runs the owner lookup, the allocation and the free in turn.
// Reset marks every class head empty and clears the page count and the
// used-byte counters; the link and owner memories need no clearing since
// only entries of claimed pages are ever read.
module size_class_slab_allocator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic [15:0]                         request_size,
    input  logic                                address_present,
    input  logic [scsa_pkg::AddrW-1:0]          block_in,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [scsa_pkg::AddrW-1:0]          block_out,
    output logic [11:0]                         copy_bytes,
    output logic [scsa_pkg::CountW-1:0]         used_bytes_now
);
    import scsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_ALLOC  = 9'b000001000,
        S_CLAIM  = 9'b000010000,
        S_POPRD  = 9'b000100000,
        S_POP    = 9'b001000000,
        S_FREE   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;

    logic [1:0]             kind_reg;
    logic [15:0]            size_reg;
    logic                   present_reg;
    logic [AddrW-1:0]       addr_reg;
    logic [ClassW-1:0]      oc_reg, oc_next;     // class of old block
    logic [ClassW-1:0]      ac_reg, ac_next;     // class for allocation
    logic [1:0]             stat_reg, stat_next;
    logic [AddrW-1:0]       res_reg, res_next;
    logic [11:0]            copy_reg, copy_next;
    logic                   done_reg;
    logic [SlotW:0]         slot_reg, slot_next; // claim sweep slot
    logic [PageW:0]         pages_reg, pages_next;
    logic                   accept;

    logic [ClassCount-1:0]  hv_reg, hv_next;
    logic [IdxW-1:0]        head_reg [ClassCount];
    logic [IdxW-1:0]        head_next [ClassCount];
    logic [CountW-1:0]      cu_reg [ClassCount];
    logic [CountW-1:0]      cu_next [ClassCount];
    logic [CountW-1:0]      tot_reg, tot_next;

    // Link memory: {valid, next index}.
    logic                   lk_we;
    logic [IdxW-1:0]        lk_waddr, lk_raddr;
    logic [IdxW:0]          lk_wdata, lk_rdata;
    // Page owner memory.
    logic                   ow_we;
    logic [PageW-1:0]       ow_waddr;
    logic [ClassW-1:0]      ow_wdata, ow_rdata;

    scsa_ram #(.Width(IdxW+1), .Depth(LinkDepth)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );

    scsa_ram #(.Width(ClassW), .Depth(PageCount)) u_owner (
        .clk(clk), .we(ow_we), .waddr(ow_waddr), .wdata(ow_wdata),
        .raddr(addr_reg[AddrW-1 -: PageW]), .rdata(ow_rdata)
    );

    assign accept = start && !busy;

    // Smallest usable class that fits the request.
    logic                   fit_ok;
    logic [ClassW-1:0]      fit_c;
    always_comb
    begin
        fit_ok = 1'b0;
        fit_c  = '0;
        for (int c = ClassCount-1; c >= 0; c--)
        begin
            if (class_usable(ClassW'(c)) &&
                {3'b0, class_bytes(ClassW'(c))} >= size_reg)
            begin
                fit_ok = 1'b1;
                fit_c  = ClassW'(c);
            end
        end
    end

    // Address check against the owning class.
    logic [OffW-1:0]        off;
    logic [12:0]            ob;
    logic                   addr_ok;
    logic [PageW-1:0]       cur_page;
    always_comb
    begin
        off     = addr_reg[OffW-1:0];
        ob      = class_bytes(ow_rdata);
        addr_ok = (ow_rdata < ClassW'(ClassCount)) &&
                  ({1'b0, off} >= ob) &&
                  (({1'b0, off} & (ob - 13'd1)) == 13'd0) &&
                  ({1'b0, off} + ob <= 14'(PageBytes));
    end
    assign cur_page = pages_reg[PageW-1:0];

    logic [SlotW:0]         last_slot;
    logic [IdxW-1:0]        claim_idx;
    assign last_slot = (SlotW+1)'(LinkDepth / PageCount) - class_units(ac_reg);
    assign claim_idx = {cur_page, slot_reg[SlotW-1:0]};

    always_comb
    begin
        state_next = state_reg;
        oc_next    = oc_reg;
        ac_next    = ac_reg;
        stat_next  = stat_reg;
        res_next   = res_reg;
        copy_next  = copy_reg;
        slot_next  = slot_reg;
        pages_next = pages_reg;
        hv_next    = hv_reg;
        tot_next   = tot_reg;
        for (int c = 0; c < ClassCount; c++)
        begin
            head_next[c] = head_reg[c];
            cu_next[c]   = cu_reg[c];
        end
        lk_we    = 1'b0;
        lk_waddr = addr_reg[AddrW-1 -: IdxW];
        lk_wdata = {hv_reg[oc_reg], head_reg[oc_reg]};
        lk_raddr = head_reg[ac_reg];
        ow_we    = 1'b0;
        ow_waddr = cur_page;
        ow_wdata = ac_reg;

        case (state_reg)
            S_IDLE:
            begin
                stat_next = StatOk;
                res_next  = '0;
                copy_next = '0;
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // Owner read is in flight for block_in's page.
                if (kind_reg == KindAlloc ||
                    (kind_reg == KindRealloc && !present_reg))
                begin
                    state_next = S_ALLOC;
                end
                else if ((kind_reg == KindFree || kind_reg == KindRealloc) &&
                         present_reg &&
                         {1'b0, addr_reg[AddrW-1 -: PageW]} < pages_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    stat_next  = StatBadAddr;
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                oc_next = ow_rdata;
                if (!addr_ok)
                begin
                    stat_next  = StatBadAddr;
                    state_next = S_DONE;
                end
                else if (kind_reg == KindFree)
                begin
                    state_next = S_FREE;
                end
                else if ({3'b0, ob} >= size_reg)
                begin
                    res_next   = addr_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                ac_next = fit_c;
                if (!fit_ok)
                begin
                    stat_next  = StatNoClass;
                    state_next = S_DONE;
                end
                else if (hv_reg[fit_c])
                begin
                    state_next = S_POPRD;
                end
                else if (pages_reg >= (PageW+1)'(PageCount))
                begin
                    stat_next  = StatNoPage;
                    state_next = S_DONE;
                end
                else
                begin
                    slot_next  = class_units(fit_c);
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM:
            begin
                // One link per cycle, chaining the page's blocks in order.
                lk_we    = 1'b1;
                lk_waddr = claim_idx;
                lk_wdata = (slot_reg == last_slot) ? '0 :
                           {1'b1, cur_page, SlotW'(slot_reg + class_units(ac_reg))};
                slot_next = slot_reg + class_units(ac_reg);
                if (slot_reg == last_slot)
                begin
                    ow_we              = 1'b1;
                    pages_next         = pages_reg + 1'b1;
                    hv_next[ac_reg]    = 1'b1;
                    head_next[ac_reg]  = {cur_page, SlotW'(class_units(ac_reg))};
                    state_next         = S_POPRD;
                end
            end
            S_POPRD:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                res_next          = {head_reg[ac_reg], ($clog2(SmallBytes))'(0)};
                hv_next[ac_reg]   = lk_rdata[IdxW];
                head_next[ac_reg] = lk_rdata[IdxW-1:0];
                cu_next[ac_reg]   = ({1'b0, cu_reg[ac_reg]} +
                                     20'(class_bytes(ac_reg)) > 20'(CountMax)) ?
                                    CountMax : cu_reg[ac_reg] + 19'(class_bytes(ac_reg));
                tot_next          = ({1'b0, tot_reg} +
                                     20'(class_bytes(ac_reg)) > 20'(CountMax)) ?
                                    CountMax : tot_reg + 19'(class_bytes(ac_reg));
                if (kind_reg == KindRealloc && present_reg)
                begin
                    copy_next  = 12'(class_bytes(oc_reg));
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE:
            begin
                lk_we             = 1'b1;
                hv_next[oc_reg]   = 1'b1;
                head_next[oc_reg] = addr_reg[AddrW-1 -: IdxW];
                cu_next[oc_reg]   = (cu_reg[oc_reg] > 19'(class_bytes(oc_reg))) ?
                                    cu_reg[oc_reg] - 19'(class_bytes(oc_reg)) : '0;
                tot_next          = (tot_reg > 19'(class_bytes(oc_reg))) ?
                                    tot_reg - 19'(class_bytes(oc_reg)) : '0;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pages_reg <= '0;
            hv_reg    <= '0;
            tot_reg   <= '0;
            done_reg  <= 1'b0;
            for (int c = 0; c < ClassCount; c++)
            begin
                cu_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pages_reg <= pages_next;
            hv_reg    <= hv_next;
            tot_reg   <= tot_next;
            done_reg  <= (state_reg == S_DONE);
            for (int c = 0; c < ClassCount; c++)
            begin
                cu_reg[c] <= cu_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            size_reg    <= request_size;
            present_reg <= address_present;
            addr_reg    <= block_in;
        end
        oc_reg   <= oc_next;
        ac_reg   <= ac_next;
        stat_reg <= stat_next;
        res_reg  <= res_next;
        copy_reg <= copy_next;
        slot_reg <= slot_next;
        for (int c = 0; c < ClassCount; c++)
        begin
            head_reg[c] <= head_next[c];
        end
    end

    assign busy           = (state_reg != S_IDLE) || done_reg;
    assign done           = done_reg;
    assign status         = stat_reg;
    assign block_out      = (stat_reg == StatOk) ? res_reg : '0;
    assign copy_bytes     = (stat_reg == StatOk) ? copy_reg : '0;
    assign used_bytes_now = tot_reg;

    a_claim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_reg <= (PageW+1)'(PageCount))
        else $error("page count past pool size");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !done_reg && start) |=> busy)
        else $error("accepted command did not raise busy");
    a_claim_pages: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM) |-> (pages_reg < (PageW+1)'(PageCount)))
        else $error("claim with no page left");
endmodule

// ===== sim/tb_size_class_slab_allocator_top.sv =====
// Self-checking testbench for size_class_slab_allocator_top.
// Depends on scsa_pkg and the allocator RTL; results come from its own allocator model.
module tb_size_class_slab_allocator_top;
    import scsa_pkg::*;

    localparam logic [1:0] KindUnknown = 2'd3;
    localparam int CycleLimit = 2000000;
    localparam int RandomItems = 1900;

    typedef struct packed {
        logic [1:0]        st;
        logic [AddrW-1:0]  blk;
        logic [11:0]       copy;
        logic [CountW-1:0] used;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] kind = KindAlloc;
    logic [15:0] request_size = '0;
    logic address_present = 1'b0;
    logic [AddrW-1:0] block_in = '0;
    logic busy, done;
    logic [1:0] status;
    logic [AddrW-1:0] block_out;
    logic [11:0] copy_bytes;
    logic [CountW-1:0] used_bytes_now;

    // Allocator model state.
    logic              head_valid [ClassCount];
    logic [IdxW-1:0]   head_idx   [ClassCount];
    logic              next_valid [LinkDepth];
    logic [IdxW-1:0]   next_idx   [LinkDepth];
    logic [ClassW-1:0] owner      [PageCount];
    int                pages_used;
    int                class_used [ClassCount];
    int                total_used;

    alloc_result_t pending_results [$];
    int live_blocks [$];
    int last_freed;
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    size_class_slab_allocator_top dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("size_class_slab_allocator_top regression: fail");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report("result beat with nothing expected");
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                    report($sformatf("status %0d, expected %0d", status, exp_r.st));
                if (block_out !== exp_r.blk)
                    report($sformatf("block_out %h, expected %h", block_out, exp_r.blk));
                if (copy_bytes !== exp_r.copy)
                    report($sformatf("copy_bytes %0d, expected %0d",
                                     copy_bytes, exp_r.copy));
                if (used_bytes_now !== exp_r.used)
                    report($sformatf("used_bytes_now %0d, expected %0d",
                                     used_bytes_now, exp_r.used));
            end
        end
    end

    function automatic int blk_bytes(input int c);
        return SmallBytes << c;
    endfunction

    task automatic model_reset();
        for (int c = 0; c < ClassCount; c++)
        begin
            head_valid[c] = 1'b0;
            head_idx[c] = '0;
            class_used[c] = 0;
        end
        pages_used = 0;
        total_used = 0;
    endtask

    task automatic add_used(input int c);
        class_used[c] = (class_used[c] + blk_bytes(c) > CountMax) ? int'(CountMax)
                        : class_used[c] + blk_bytes(c);
        total_used = (total_used + blk_bytes(c) > CountMax) ? int'(CountMax)
                     : total_used + blk_bytes(c);
    endtask

    task automatic model_alloc(input int size, output logic [1:0] st, output int addr);
        int c;
        int base;
        int n;
        int idx;
        c = 0;
        st = StatOk;
        addr = 0;
        while (c < ClassCount && blk_bytes(c) < size)
            c++;
        if (c >= ClassCount)
        begin
            st = StatNoClass;
            return;
        end
        if (!head_valid[c])
        begin
            if (pages_used >= PageCount)
            begin
                st = StatNoPage;
                return;
            end
            // Chain the fresh page's blocks in address order, skipping the header slot.
            base = pages_used * PageBytes;
            n = PageBytes / blk_bytes(c) - 1;
            owner[pages_used] = ClassW'(c);
            pages_used++;
            for (int i = 1; i <= n; i++)
            begin
                idx = (base + i * blk_bytes(c)) / SmallBytes;
                next_valid[idx] = (i < n);
                next_idx[idx] = (i < n) ? IdxW'((base + (i + 1) * blk_bytes(c)) / SmallBytes)
                                        : '0;
            end
            head_valid[c] = 1'b1;
            head_idx[c] = IdxW'((base + blk_bytes(c)) / SmallBytes);
        end
        idx = int'(head_idx[c]);
        head_valid[c] = next_valid[idx];
        head_idx[c] = next_idx[idx];
        add_used(c);
        addr = idx * SmallBytes;
    endtask

    function automatic bit block_class(input int addr, output int c);
        int page;
        int off;
        int s;
        page = addr / PageBytes;
        off = addr % PageBytes;
        c = 0;
        if (page >= pages_used)
            return 1'b0;
        c = int'(owner[page]);
        s = blk_bytes(c);
        return !(off < s || off % s != 0 || off + s > PageBytes);
    endfunction

    task automatic model_release(input int addr, input int c);
        int idx;
        idx = addr / SmallBytes;
        next_valid[idx] = head_valid[c];
        next_idx[idx] = head_idx[c];
        head_valid[c] = 1'b1;
        head_idx[c] = IdxW'(idx);
        class_used[c] = (class_used[c] > blk_bytes(c)) ? class_used[c] - blk_bytes(c) : 0;
        total_used = (total_used > blk_bytes(c)) ? total_used - blk_bytes(c) : 0;
    endtask

    task automatic drop_live(input int addr);
        for (int i = 0; i < live_blocks.size(); i++)
        begin
            if (live_blocks[i] == addr)
            begin
                live_blocks.delete(i);
                return;
            end
        end
    endtask

    task automatic predict_request(input logic [1:0] k, input int size, input bit present,
                                   input int addr, output alloc_result_t r);
        logic [1:0] st;
        int res;
        int cp;
        int c;
        st = StatOk;
        res = 0;
        cp = 0;
        if (k == KindAlloc || (k == KindRealloc && !present))
        begin
            model_alloc(size, st, res);
            if (st == StatOk)
                live_blocks.push_back(res);
        end
        else if (k == KindFree)
        begin
            if (!present || !block_class(addr, c))
            begin
                st = StatBadAddr;
            end
            else
            begin
                model_release(addr, c);
                drop_live(addr);
                last_freed = addr;
            end
        end
        else if (k == KindRealloc)
        begin
            if (!block_class(addr, c))
            begin
                st = StatBadAddr;
            end
            else if (size <= blk_bytes(c))
            begin
                res = addr;
            end
            else
            begin
                model_alloc(size, st, res);
                if (st == StatOk)
                begin
                    cp = blk_bytes(c);
                    model_release(addr, c);
                    drop_live(addr);
                    live_blocks.push_back(res);
                end
            end
        end
        else
        begin
            st = StatBadAddr;
        end
        if (st != StatOk)
        begin
            res = 0;
            cp = 0;
        end
        r.st = st;
        r.blk = AddrW'(res);
        r.copy = 12'(cp);
        r.used = CountW'(total_used);
    endtask

    // Leaves start high; the caller's pacing lowers it or the next beat reuses it.
    task automatic send_request(input logic [1:0] k, input int size, input bit present,
                                input int addr);
        alloc_result_t r;
        kind <= k;
        request_size <= 16'(size);
        address_present <= present;
        block_in <= AddrW'(addr);
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_request(k, size, present, addr, r);
        pending_results.push_back(r);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                     : $urandom_range(0, 10);
        gap = $urandom_range(1, 25);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_edge_sizes();
        int sizes [7] = '{0, 1, 32, 33, 2048, 2049, 65535};
        foreach (sizes[i])
        begin
            send_request(KindAlloc, sizes[i], 1'b0, 0);
            pace();
        end
        send_request(KindUnknown, 65535, 1'b1, 262143);
        pace();
    endtask

    task automatic test_bad_addresses();
        send_request(KindFree, 0, 1'b0, 32);
        pace();
        send_request(KindFree, 0, 1'b1, 262143);
        pace();
        send_request(KindFree, 0, 1'b1, 0);
        pace();
        send_request(KindFree, 0, 1'b1, 33);
        pace();
        // The first block is freed twice; the counters must not wrap below zero.
        send_request(KindFree, 0, 1'b1, 32);
        pace();
        send_request(KindFree, 0, 1'b1, 32);
        pace();
    endtask

    task automatic test_realloc();
        send_request(KindRealloc, 100, 1'b0, 0);
        pace();
        send_request(KindRealloc, 20, 1'b1, live_blocks[$]);
        pace();
        send_request(KindRealloc, 1000, 1'b1, live_blocks[$]);
        pace();
        send_request(KindRealloc, 4000, 1'b1, live_blocks[$]);
        pace();
        send_request(KindRealloc, 10, 1'b1, 131072);
        pace();
    endtask

    task automatic test_pause_until_drained();
        send_request(KindAlloc, 300, 1'b0, 0);
        drain();
        send_request(KindFree, 0, 1'b1, live_blocks[$]);
        drain();
    endtask

    function automatic int pick_size();
        int c;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(0, 65535);
        c = $urandom_range(0, ClassCount - 1);
        return (c == 0) ? $urandom_range(0, 32) : $urandom_range((16 << c) + 1, 32 << c);
    endfunction

    function automatic int pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (live_blocks.size() != 0 && roll < 82)
            return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if (roll < 90)
            return last_freed;
        return $urandom_range(0, 262143);
    endfunction

    task automatic test_random_traffic();
        int roll;
        for (int n = 0; n < RandomItems; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                send_request(KindAlloc, pick_size(), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 262143));
            else if (roll < 74)
                send_request(KindFree, $urandom_range(0, 65535), $urandom_range(0, 19) != 0,
                             pick_address());
            else if (roll < 96)
                send_request(KindRealloc, pick_size(), $urandom_range(0, 9) != 0,
                             pick_address());
            else
                send_request(KindUnknown, $urandom_range(0, 65535),
                             1'($urandom_range(0, 1)), $urandom_range(0, 262143));
            pace();
        end
    endtask

    initial
    begin
        model_reset();
        last_freed = 32;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_sizes();
        test_bad_addresses();
        test_realloc();
        test_pause_until_drained();
        test_random_traffic();
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("size_class_slab_allocator_top regression: pass");
        else
            $display("size_class_slab_allocator_top regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/scsa_pkg.sv
sv/scsa_ram.sv
sv/size_class_slab_allocator_top.sv
sim/tb_size_class_slab_allocator_top.sv
